### hdl/gbf_pkg.sv
`default_nettype none

package gbf_pkg;

    // default sizing
    localparam int FRONTIER_DEPTH_DEF = 64;
    localparam int COORD_BITS_DEF     = 8;

    // operation carried in the input tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // result status carried in the output tuser
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_PUSHED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y = 1'b1;

endpackage

`default_nettype wire

### hdl/greedy_best_first_frontier_top.sv
// push, empty pop and full push: straight to the finish state, which loads the result
// register once it is free; pop of a nonempty frontier: a scan, then the close-up behind
// the winner, both walking the single ram read port one entry per cycle
// one item in flight; the next beat is taken the cycle after the result register loads
// aresetn (synchronous, active low) empties the frontier and clears the goal to zero;
// the entry ram itself is not cleared, only entries below the fill count are ever read
`default_nettype none

module greedy_best_first_frontier_top #(
    parameter int FRONTIER_DEPTH = gbf_pkg::FRONTIER_DEPTH_DEF,
    parameter int COORD_BITS     = gbf_pkg::COORD_BITS_DEF,
    localparam int CNT_W  = $clog2(FRONTIER_DEPTH + 1),
    localparam int DIST_W = COORD_BITS + 1,
    localparam int S_DW   = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int M_RAW  = 3 * COORD_BITS + 1 + CNT_W,
    localparam int M_DW   = ((M_RAW + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,

    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [gbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [COORD_BITS-1:0]          cfg_wdata,

    // command stream
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [S_DW-1:0]                s_axis_tdata,  // cell_x, cell_y, zero pad
    input  wire logic                           s_axis_tuser,  // op

    // result stream
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [M_DW-1:0]                     m_axis_tdata,  // out_x, out_y, out_distance,
                                                               // fill_count, zero pad
    output logic [gbf_pkg::STATUS_W-1:0]        m_axis_tuser   // status
);

    localparam int AW    = $clog2(FRONTIER_DEPTH);
    localparam int ENT_W = 3 * COORD_BITS + 1;   // {dist, row, col}

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]                     state_reg, state_next;
    logic [CNT_W-1:0]               held_reg, held_next;
    logic [COORD_BITS-1:0]          dest_x_reg, dest_x_next;
    logic [COORD_BITS-1:0]          dest_y_reg, dest_y_next;

    // walk over the entry ram: read issue pointer and the beat coming back
    logic [CNT_W-1:0]               issue_reg, issue_next;
    logic                           pend_reg, pend_next;
    logic [CNT_W-1:0]               pend_idx_reg, pend_idx_next;

    // running minimum, also the pending result payload
    logic [CNT_W-1:0]               best_idx_reg, best_idx_next;
    logic [ENT_W-1:0]               best_ent_reg, best_ent_next;
    logic [gbf_pkg::STATUS_W-1:0]   res_status_reg, res_status_next;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic [ENT_W-1:0]               m_ent_reg, m_ent_next;
    logic [gbf_pkg::STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [CNT_W-1:0]               m_fill_reg, m_fill_next;

    // entry ram
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [ENT_W-1:0]               ram_wdata;
    logic [AW-1:0]                  ram_raddr;
    logic [ENT_W-1:0]               ram_rdata;

    // push distance
    logic [COORD_BITS-1:0]          cell_x, cell_y;
    logic [COORD_BITS-1:0]          diff_x, diff_y;
    logic [DIST_W-1:0]              push_dist;

    // shared compare and pointer math
    logic [CNT_W-1:0]               held_m1;
    logic [CNT_W-1:0]               shift_dst;
    logic [DIST_W-1:0]              rd_dist, best_dist;
    logic                           rd_better;

    gbf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (FRONTIER_DEPTH)
    ) u_entries (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cell_x    = s_axis_tdata[COORD_BITS-1:0];
    assign cell_y    = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign diff_x    = (cell_x > dest_x_reg) ? (cell_x - dest_x_reg) : (dest_x_reg - cell_x);
    assign diff_y    = (cell_y > dest_y_reg) ? (cell_y - dest_y_reg) : (dest_y_reg - cell_y);
    assign push_dist = {1'b0, diff_x} + {1'b0, diff_y};

    assign held_m1   = held_reg - 1'b1;
    assign shift_dst = pend_idx_reg - 1'b1;
    assign rd_dist   = ram_rdata[ENT_W-1 -: DIST_W];
    assign best_dist = best_ent_reg[ENT_W-1 -: DIST_W];
    // strict less keeps the earliest entry on a tie
    assign rd_better = (pend_idx_reg == '0) || (rd_dist < best_dist);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = M_DW'({m_fill_reg, m_ent_reg});
    assign m_axis_tuser  = m_status_reg;

    always_comb begin
        state_next      = state_reg;
        held_next       = held_reg;
        dest_x_next     = dest_x_reg;
        dest_y_next     = dest_y_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        best_idx_next   = best_idx_reg;
        best_ent_next   = best_ent_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_ent_next      = m_ent_reg;
        m_status_next   = m_status_reg;
        m_fill_next     = m_fill_reg;
        ram_we          = 1'b0;
        ram_waddr       = held_reg[AW-1:0];
        ram_wdata       = {push_dist, cell_y, cell_x};
        ram_raddr       = issue_reg[AW-1:0];

        // goal registers
        if (cfg_we) begin
            case (cfg_index)
                gbf_pkg::REG_DEST_X: dest_x_next = cfg_wdata;
                gbf_pkg::REG_DEST_Y: dest_y_next = cfg_wdata;
                default: ;
            endcase
        end

        // result beat taken downstream
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    best_ent_next = '0;
                    state_next    = S_FINISH;
                    if (s_axis_tuser == gbf_pkg::OP_PUSH) begin
                        if (held_reg == CNT_W'(FRONTIER_DEPTH)) begin
                            res_status_next = gbf_pkg::ST_FULL;
                        end else begin
                            // append at the tail
                            ram_we          = 1'b1;
                            held_next       = held_reg + 1'b1;
                            res_status_next = gbf_pkg::ST_PUSHED;
                        end
                    end else if (held_reg == '0) begin
                        res_status_next = gbf_pkg::ST_EMPTY;
                    end else begin
                        issue_next = '0;
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // one read issued and one compare done per cycle
                if (issue_reg < held_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg;
                    issue_next    = issue_reg + 1'b1;
                end
                if (pend_reg) begin
                    if (rd_better) begin
                        best_idx_next = pend_idx_reg;
                        best_ent_next = ram_rdata;
                    end
                    if (pend_idx_reg == held_m1) begin
                        // start the close-up behind the winner
                        pend_next  = 1'b0;
                        issue_next = best_idx_next + 1'b1;
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT: begin
                // read entry i, write it back at i-1 in the cycle after
                if (issue_reg < held_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg;
                    issue_next    = issue_reg + 1'b1;
                end
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = shift_dst[AW-1:0];
                    ram_wdata = ram_rdata;
                end
                if (issue_reg >= held_reg) begin
                    pend_next       = 1'b0;
                    held_next       = held_m1;
                    res_status_next = gbf_pkg::ST_POPPED;
                    state_next      = S_FINISH;
                end
            end

            S_FINISH: begin
                // wait for the output register to be free
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_ent_next    = best_ent_reg;
                    m_status_next = res_status_reg;
                    m_fill_next   = held_reg;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            held_reg    <= '0;
            dest_x_reg  <= '0;
            dest_y_reg  <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            held_reg    <= held_next;
            dest_x_reg  <= dest_x_next;
            dest_y_reg  <= dest_y_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        best_idx_reg   <= best_idx_next;
        best_ent_reg   <= best_ent_next;
        res_status_reg <= res_status_next;
        m_ent_reg      <= m_ent_next;
        m_status_reg   <= m_status_next;
        m_fill_reg     <= m_fill_next;
    end

endmodule

`default_nettype wire

### hdl/gbf_ram.sv
`default_nettype none

module gbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int DEPTH      = gbf_pkg::FRONTIER_DEPTH_DEF;
    localparam int IDLE_LIMIT = 3000;   // cycles with no beat on either side
    localparam int LONG_HOLD  = 400;    // receiver hold-off for the back-pressure test
    localparam int SETTLE     = 140;    // worst pop: full scan plus full close-up
    localparam int PHASE_LEN  = 130;

    // one result beat, split into its fields
    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [8:0] distance;
        logic [1:0] status;
        logic [6:0] fill;
    } frontier_result_t;

    // clock, reset and dut ports; the driven inputs are all known from time zero
    logic                          aclk          = 1'b0;
    logic                          aresetn       = 1'b0;
    logic                          cfg_we        = 1'b0;
    logic [gbf_pkg::CFG_IDX_W-1:0] cfg_index     = gbf_pkg::REG_DEST_X;
    logic [7:0]                    cfg_wdata     = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [15:0]                   s_axis_tdata  = '0;   // cell_x, cell_y
    logic                          s_axis_tuser  = gbf_pkg::OP_PUSH;   // op
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [31:0]                   m_axis_tdata;  // out_x, out_y, out_distance, fill_count
    logic [gbf_pkg::STATUS_W-1:0]  m_axis_tuser;  // status

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    greedy_best_first_frontier_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------
    // frontier predictor: own copy of goal and held entries
    // ------------------------------------------------------------------
    logic [7:0] goal_x = '0;
    logic [7:0] goal_y = '0;
    logic [7:0] held_col  [DEPTH];
    logic [7:0] held_row  [DEPTH];
    logic [8:0] held_dist [DEPTH];
    int         held_n = 0;

    frontier_result_t nearest_q[$];   // results still owed by the dut, oldest first
    int               fail_count = 0;

    // knobs set by the test sequence for the command side and the result side
    bit steady_tx = 1'b0;   // sender offers back to back
    bit steady_rx = 1'b0;   // receiver always ready
    bit hold_req  = 1'b0;   // ask the receiver for one long hold-off

    function automatic logic [8:0] manhattan(input logic [7:0] ax, input logic [7:0] ay,
                                             input logic [7:0] bx, input logic [7:0] by);
        logic [8:0] dx;
        logic [8:0] dy;
        dx = (ax > bx) ? 9'(ax - bx) : 9'(bx - ax);
        dy = (ay > by) ? 9'(ay - by) : 9'(by - ay);
        return dx + dy;
    endfunction

    // apply one accepted command to the predictor and queue its result
    function automatic void predict_step(input logic op, input logic [7:0] x,
                                         input logic [7:0] y);
        frontier_result_t r;
        int               best;
        r = '0;
        if (op == gbf_pkg::OP_PUSH) begin
            if (held_n >= DEPTH) begin
                r.status = gbf_pkg::ST_FULL;
            end else begin
                held_col[held_n]  = x;
                held_row[held_n]  = y;
                held_dist[held_n] = manhattan(x, y, goal_x, goal_y);
                held_n++;
                r.status = gbf_pkg::ST_PUSHED;
            end
        end else if (held_n == 0) begin
            r.status = gbf_pkg::ST_EMPTY;
        end else begin
            // strict less-than keeps the earliest entry on a tie
            best = 0;
            for (int i = 1; i < held_n; i++) begin
                if (held_dist[i] < held_dist[best]) best = i;
            end
            r.x        = held_col[best];
            r.y        = held_row[best];
            r.distance = held_dist[best];
            // close up behind the removed entry
            for (int i = best; i + 1 < held_n; i++) begin
                held_col[i]  = held_col[i + 1];
                held_row[i]  = held_row[i + 1];
                held_dist[i] = held_dist[i + 1];
            end
            held_n--;
            r.status = gbf_pkg::ST_POPPED;
        end
        r.fill = 7'(held_n);
        nearest_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------
    // idle length before a beat: mostly none or short, now and then long
    function automatic int tx_gap();
        int r;
        if (steady_tx) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // offer one command beat and hold it until accepted
    task automatic send_cmd(input logic op, input logic [7:0] x, input logic [7:0] y);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {y, x};
        do @(posedge aclk); while (!s_axis_tready);
        predict_step(op, x, y);
    endtask

    // coordinates biased toward the corners of the grid
    function automatic logic [7:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_random(input int push_pct);
        logic op;
        op = ($urandom_range(0, 99) < push_pct) ? gbf_pkg::OP_PUSH : gbf_pkg::OP_POP;
        send_cmd(op, rand_coord(), rand_coord());
    endtask

    // stop offering and wait until every owed result has been taken
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (nearest_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // goal registers are only written while nothing is in flight
    task automatic set_goal(input logic [7:0] gx, input logic [7:0] gy);
        cfg_we    <= 1'b1;
        cfg_index <= gbf_pkg::REG_DEST_X;
        cfg_wdata <= gx;
        @(posedge aclk);
        goal_x = gx;
        cfg_index <= gbf_pkg::REG_DEST_Y;
        cfg_wdata <= gy;
        @(posedge aclk);
        goal_y = gy;
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge aclk) begin
        if (hold_req) begin
            stall_left = LONG_HOLD;
            hold_req   = 1'b0;
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else if (steady_rx || $urandom_range(0, 99) < 70) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(0, 3);
        end
    end

    // compare every result beat against the oldest owed result
    always @(posedge aclk) begin : check_result
        frontier_result_t got;
        frontier_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.x        = m_axis_tdata[7:0];
            got.y        = m_axis_tdata[15:8];
            got.distance = m_axis_tdata[24:16];
            got.fill     = m_axis_tdata[31:25];
            got.status   = m_axis_tuser;
            if (nearest_q.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: result beat with nothing owed: %s%0d %0d %0d %0d %0d",
                             $realtime, "x y d st fill = ", got.x, got.y, got.distance,
                             got.status, got.fill);
            end else begin
                want = nearest_q.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.distance !== want.distance ||
                    got.status !== want.status || got.fill !== want.fill) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%0t: mismatch exp x=%0d y=%0d d=%0d st=%0d fill=%0d,",
                                  " got x=%0d y=%0d d=%0d st=%0d fill=%0d"},
                                 $realtime, want.x, want.y, want.distance, want.status,
                                 want.fill, got.x, got.y, got.distance, got.status,
                                 got.fill);
                end
            end
        end
    end

    // watchdog: too long with no beat anywhere means the block has hung
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // pops on a fresh frontier report empty, goal starts at the origin
    task automatic test_empty_after_reset();
        send_cmd(gbf_pkg::OP_POP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_cmd(gbf_pkg::OP_POP, 8'hff, 8'hff);
        send_cmd(gbf_pkg::OP_PUSH, 8'h00, 8'h00);
        send_cmd(gbf_pkg::OP_POP, 8'h00, 8'h00);
    endtask

    // corner cells, largest distance, and a tie that the earlier push must win
    task automatic test_extreme_coords();
        send_cmd(gbf_pkg::OP_PUSH, 8'hff, 8'hff);   // distance 510
        send_cmd(gbf_pkg::OP_PUSH, 8'hff, 8'h00);   // 255
        send_cmd(gbf_pkg::OP_PUSH, 8'h00, 8'hff);   // 255, loses the tie
        send_cmd(gbf_pkg::OP_PUSH, 8'h00, 8'h00);   // 0
        repeat (5) send_cmd(gbf_pkg::OP_POP, 8'hff, 8'hff);   // last one hits empty
    endtask

    // distance is fixed when pushed, not when popped
    task automatic test_goal_change_with_held();
        drain_results();
        set_goal(8'hff, 8'hff);
        send_cmd(gbf_pkg::OP_PUSH, 8'h00, 8'h00);   // 510 against the far corner
        send_cmd(gbf_pkg::OP_PUSH, 8'd200, 8'd100); // 210
        drain_results();
        set_goal(8'h00, 8'h00);
        send_cmd(gbf_pkg::OP_PUSH, 8'd1, 8'd1);     // 2
        repeat (4) send_cmd(gbf_pkg::OP_POP, 8'h00, 8'h00);
    endtask

    // fill to the depth, knock on the full frontier, then empty it again
    task automatic test_full_frontier();
        drain_results();
        set_goal(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        repeat (DEPTH) send_cmd(gbf_pkg::OP_PUSH, rand_coord(), rand_coord());
        repeat (3) send_cmd(gbf_pkg::OP_PUSH, rand_coord(), rand_coord());
        repeat (DEPTH + 1) send_cmd(gbf_pkg::OP_POP, rand_coord(), rand_coord());
    endtask

    // receiver holds off long while commands keep coming, so the input stalls
    task automatic test_back_pressure();
        repeat (10) send_cmd(gbf_pkg::OP_PUSH, rand_coord(), rand_coord());
        hold_req = 1'b1;
        repeat (16) send_random(50);
    endtask

    // sender stops mid-stream until every result is back, then resumes
    task automatic test_pause_mid_stream();
        repeat (20) send_random(60);
        drain_results();
        repeat (20) send_random(40);
    endtask

    // phases of fill-heavy, drain-heavy and balanced traffic under varied goals
    task automatic test_random_phases();
        int push_pct;
        for (int p = 0; p < 12; p++) begin
            drain_results();
            case (p)
                0: begin set_goal(8'h00, 8'h00); end
                1: begin set_goal(8'hff, 8'hff); end
                2: begin set_goal(8'h00, 8'hff); end
                3: begin set_goal(8'hff, 8'h00); end
                default: begin
                    set_goal(rand_coord(), rand_coord());
                end
            endcase
            push_pct  = (p % 3 == 0) ? 80 : (p % 3 == 1) ? 25 : 50;
            // some phases run with no idling at all
            steady_tx = (p % 4 == 3);
            steady_rx = (p % 4 == 3) || (p % 5 == 4);
            repeat (PHASE_LEN) send_random(push_pct);
        end
        steady_tx = 1'b0;
        steady_rx = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_after_reset();
        test_extreme_coords();
        test_goal_change_with_held();
        test_full_frontier();
        test_back_pressure();
        test_pause_mid_stream();
        test_random_phases();

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0 && nearest_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
